// ===== design/line_to_tile_rasterizer_defines.svh =====
// Assertion helpers for the rasterizer RTL; only ltr_back includes them.
`ifndef LINE_TO_TILE_RASTERIZER_DEFINES_SVH
`define LINE_TO_TILE_RASTERIZER_DEFINES_SVH

// Condition holds in the same cycle.
`define LTR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Condition holds in the following cycle.
`define LTR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ltr_pkg.sv =====
`timescale 1ns / 1ps

package ltr_pkg;

    localparam logic [3:0] WALK_LIMIT = 4'd15;
    localparam logic [3:0] LAST_INDEX = 4'd15;
    localparam int         ERR_W      = 6;

    localparam logic signed [1:0] STEP_NONE = 2'sb00;
    localparam logic signed [1:0] STEP_POS  = 2'sb01;
    localparam logic signed [1:0] STEP_NEG  = 2'sb11;

    typedef struct packed {
        logic [2:0] start_x;
        logic [2:0] start_y;
        logic [2:0] end_x;
        logic [2:0] end_y;
    } t_line_req;

    typedef struct packed {
        logic [7:0] tile_byte;
        logic [3:0] byte_index;
        logic       last;
    } t_tile_beat;

    typedef struct packed {
        t_line_req          req;
        logic [2:0]         dx;
        logic [2:0]         dy;
        logic signed [1:0]  sx;
        logic signed [1:0]  sy;
    } t_line_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_EMIT
    } t_back_state;

endpackage

// ===== design/ltr_front.sv =====
`timescale 1ns / 1ps

module ltr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ltr_pkg::t_line_req   i_req,
    input  ltr_pkg::t_q_status   i_q_status,
    output logic                 o_push,
    output ltr_pkg::t_line_job   o_job
);

    logic                r_valid;
    ltr_pkg::t_line_job  r_job;
    ltr_pkg::t_line_job  n_job;
    logic                accept;
    logic signed [3:0]   diff_x;
    logic signed [3:0]   diff_y;

    assign busy   = r_valid && i_q_status.full;
    assign accept = start && !busy;
    assign o_push = r_valid && !i_q_status.full;
    assign o_job  = r_job;

    always_comb begin
        diff_x    = $signed({1'b0, i_req.end_x}) - $signed({1'b0, i_req.start_x});
        diff_y    = $signed({1'b0, i_req.end_y}) - $signed({1'b0, i_req.start_y});
        n_job.req = i_req;
        n_job.dx  = diff_x[3] ? 3'(-diff_x) : diff_x[2:0];
        n_job.dy  = diff_y[3] ? 3'(-diff_y) : diff_y[2:0];
        n_job.sx  = (diff_x == 4'sd0) ? ltr_pkg::STEP_NONE
                  : (diff_x[3] ? ltr_pkg::STEP_NEG : ltr_pkg::STEP_POS);
        n_job.sy  = (diff_y == 4'sd0) ? ltr_pkg::STEP_NONE
                  : (diff_y[3] ? ltr_pkg::STEP_NEG : ltr_pkg::STEP_POS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

// ===== design/ltr_queue.sv =====
`timescale 1ns / 1ps

module ltr_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ltr_pkg::t_line_job   i_data,
    input  logic                 i_pop,
    output ltr_pkg::t_line_job   o_data,
    output ltr_pkg::t_q_status   o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ltr_pkg::t_line_job  r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_data         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/ltr_back.sv =====
`timescale 1ns / 1ps
`include "line_to_tile_rasterizer_defines.svh"

module ltr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ltr_pkg::t_q_status   i_q_status,
    input  ltr_pkg::t_line_job   i_job,
    output logic                 o_pop,
    output logic                 o_strobe,
    output ltr_pkg::t_tile_beat  o_beat
);

    ltr_pkg::t_back_state          r_state;
    ltr_pkg::t_back_state          n_state;
    ltr_pkg::t_line_job            r_job;
    logic [2:0]                    r_px;
    logic [2:0]                    r_py;
    logic signed [ltr_pkg::ERR_W-1:0] r_err;
    logic signed [ltr_pkg::ERR_W-1:0] n_err;
    logic [3:0]                    r_steps;
    logic [3:0]                    r_idx;
    logic [7:0]                    r_rows [8];
    logic                          walking;
    logic signed [ltr_pkg::ERR_W:0] twice;
    logic                          step_x;
    logic                          step_y;
    logic [7:0]                    pix_mask;

    assign walking  = ((r_px != r_job.req.end_x) || (r_py != r_job.req.end_y))
                   && (r_steps != ltr_pkg::WALK_LIMIT);
    assign twice    = {r_err, 1'b0};
    assign step_x   = twice > ($signed((ltr_pkg::ERR_W + 1)'(0))
                    - $signed({{(ltr_pkg::ERR_W - 2){1'b0}}, r_job.dy}));
    assign step_y   = twice < $signed({{(ltr_pkg::ERR_W - 2){1'b0}}, r_job.dx});
    assign pix_mask = 8'h80 >> r_px;

    always_comb begin
        n_err = r_err;
        if (step_x) begin
            n_err = n_err - $signed({{(ltr_pkg::ERR_W - 3){1'b0}}, r_job.dy});
        end
        if (step_y) begin
            n_err = n_err + $signed({{(ltr_pkg::ERR_W - 3){1'b0}}, r_job.dx});
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ltr_pkg::BK_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = ltr_pkg::BK_WALK;
                end
            end
            ltr_pkg::BK_WALK: begin
                if (!walking) begin
                    n_state = ltr_pkg::BK_EMIT;
                end
            end
            ltr_pkg::BK_EMIT: begin
                if (r_idx == ltr_pkg::LAST_INDEX) begin
                    n_state = ltr_pkg::BK_IDLE;
                end
            end
            default: n_state = ltr_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop             = (r_state == ltr_pkg::BK_IDLE) && !i_q_status.empty;
        o_strobe          = (r_state == ltr_pkg::BK_EMIT);
        o_beat.tile_byte  = r_rows[r_idx[2:0]];
        o_beat.byte_index = r_idx;
        o_beat.last       = (r_idx == ltr_pkg::LAST_INDEX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ltr_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ltr_pkg::BK_IDLE: begin
                if (o_pop) begin
                    r_job   <= i_job;
                    r_px    <= i_job.req.start_x;
                    r_py    <= i_job.req.start_y;
                    r_err   <= $signed({{(ltr_pkg::ERR_W - 3){1'b0}}, i_job.dx})
                             - $signed({{(ltr_pkg::ERR_W - 3){1'b0}}, i_job.dy});
                    r_steps <= '0;
                    r_idx   <= '0;
                    for (int i = 0; i < 8; i++) begin
                        r_rows[i] <= '0;
                    end
                end
            end
            ltr_pkg::BK_WALK: begin
                r_rows[r_py] <= r_rows[r_py] | pix_mask;
                if (walking) begin
                    r_err   <= n_err;
                    r_steps <= r_steps + 4'd1;
                    if (step_x) begin
                        r_px <= r_px + 3'({r_job.sx[1], r_job.sx});
                    end
                    if (step_y) begin
                        r_py <= r_py + 3'({r_job.sy[1], r_job.sy});
                    end
                end
            end
            ltr_pkg::BK_EMIT: begin
                r_idx <= r_idx + 4'd1;
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    `LTR_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, o_pop, !i_q_status.empty, "pop from empty queue")
    `LTR_ASSERT_NOW(a_last_index, i_clk, i_rst_n, o_strobe && o_beat.last, o_beat.byte_index == ltr_pkg::LAST_INDEX, "last flag off final beat")
    `LTR_ASSERT_NEXT(a_beat_run, i_clk, i_rst_n, o_strobe && !o_beat.last, o_strobe && (o_beat.byte_index == 4'($past(o_beat.byte_index) + 4'd1)), "tile beats not contiguous")
    `LTR_ASSERT_NEXT(a_tile_start, i_clk, i_rst_n, (r_state == ltr_pkg::BK_WALK) && !walking, o_strobe && (o_beat.byte_index == 4'd0), "tile did not start at beat zero")

endmodule

// ===== design/line_to_tile_rasterizer.sv =====
`timescale 1ns / 1ps
// Flow: a taken start is registered in the front stage and pushed into the job queue; the
// single walk/emit back end pops it, walks n = max(|dx|, |dy|) <= 7 line steps, one per cycle,
// then emits a 16-beat tile, one beat per cycle, and then returns to idle to pull the next job.
// A two-entry job queue sits between front and back; busy rises only when it and the
// front stage are both full. Beats cannot be stalled. Reset (i_rst_n low, synchronous)
// empties the queue and idles both ends; no beat is in flight afterward.

module line_to_tile_rasterizer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ltr_pkg::t_line_req   i_req,
    output logic                 o_strobe,
    output ltr_pkg::t_tile_beat  o_beat
);

    ltr_pkg::t_q_status  q_status;
    ltr_pkg::t_line_job  push_job;
    ltr_pkg::t_line_job  pop_job;
    logic                push;
    logic                pop;

    ltr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    ltr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_job),
        .i_pop    (pop),
        .o_data   (pop_job),
        .o_status (q_status)
    );

    ltr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_job      (pop_job),
        .o_pop      (pop),
        .o_strobe   (o_strobe),
        .o_beat     (o_beat)
    );

endmodule
